// File: rtl/nept_pkg.sv
package nept_pkg;

	// Image limits
	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;
	localparam int MAX_SAMPLES = 4;

	// Field and register widths
	localparam int X_W      = 7;
	localparam int Y_W      = 7;
	localparam int S_W      = 2;
	localparam int VAL_W    = 8;
	localparam int DIM_W    = 8;
	localparam int SPP_W    = 3;
	localparam int TOL_W    = 9;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;

	// Store geometry
	localparam int PIX_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT * MAX_SAMPLES);
	localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT * MAX_SAMPLES;
	localparam int PROD_W  = Y_W + DIM_W;
	localparam int AFULL_W = PIX_W + SPP_W;

	// Neighborhood walk: centre first, then the eight neighbors
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_CENTRE = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LAST   = POS_W'(8);

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OFF_NEG,
		OFF_ZERO,
		OFF_POS
	} off_t;

	typedef struct packed {
		logic             req_type;
		logic [X_W-1:0]   x;
		logic [Y_W-1:0]   y;
		logic [S_W-1:0]   sample;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic is_edge;
		logic coord_error;
	} rsp_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] addr;
		logic [VAL_W-1:0]  wdata;
	} mem_cmd_t;

	// Saturate a dimension register to [1, limit]
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] limit);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > limit)
			r = limit;
		return r;
	endfunction

	// Saturate samples per pixel to [1, MAX_SAMPLES]
	function automatic logic [SPP_W-1:0] clamp_spp(input logic [SPP_W-1:0] v);
		logic [SPP_W-1:0] r;
		r = v;
		if (v == '0)
			r = SPP_W'(1);
		else if (v > SPP_W'(MAX_SAMPLES))
			r = SPP_W'(MAX_SAMPLES);
		return r;
	endfunction

	// Column offset of a walk position
	function automatic off_t pos_dx(input logic [POS_W-1:0] pos);
		off_t r;
		case (pos)
			4'd1, 4'd2, 4'd3: r = OFF_NEG;
			4'd6, 4'd7, 4'd8: r = OFF_POS;
			default:          r = OFF_ZERO;
		endcase
		return r;
	endfunction

	// Row offset of a walk position
	function automatic off_t pos_dy(input logic [POS_W-1:0] pos);
		off_t r;
		case (pos)
			4'd1, 4'd4, 4'd6: r = OFF_NEG;
			4'd3, 4'd5, 4'd8: r = OFF_POS;
			default:          r = OFF_ZERO;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/nept_ram.sv
module nept_ram (
	input  logic                              clk,
	input  nept_pkg::mem_cmd_t                cmd,
	output logic [nept_pkg::VAL_W-1:0]        rd_data
);

	logic [nept_pkg::VAL_W-1:0] mem [nept_pkg::DEPTH];
	logic [nept_pkg::VAL_W-1:0] rd_q;

	// Write one sample
	always_ff @(posedge clk) begin
		if (cmd.we)
			mem[cmd.addr] <= cmd.wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (cmd.re)
			rd_q <= mem[cmd.addr];
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/neighborhood_edge_pixel_test.sv
// Channel   Direction  Payload            Handshake
// req       in         nept_pkg::req_t    req_valid / req_stall
// rsp       out        nept_pkg::rsp_t    rsp_valid / rsp_stall
// cfg       in         cfg_index/cfg_data cfg_we, no wait
//
// A write transaction is registered in stage 1 and then written into the store.
// A query walks centre plus eight neighbors for each sample through the single store read
// port. A query outside the image skips the walk and goes straight to the finish state.
// No clearing pass after reset. A held result keeps the next write or query open for
// acceptance; a query finishing behind a stalled result waits in its last state.
module neighborhood_edge_pixel_test (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  nept_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output nept_pkg::rsp_t                       rsp,
	input  logic                                 cfg_we,
	input  logic [nept_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nept_pkg::CFG_W-1:0]           cfg_data
);

	// Configuration registers
	logic [nept_pkg::DIM_W-1:0] width_q;
	logic [nept_pkg::DIM_W-1:0] height_q;
	logic [nept_pkg::SPP_W-1:0] spp_q;
	logic [nept_pkg::TOL_W-1:0] tol_q;

	logic [nept_pkg::DIM_W-1:0] eff_w;
	logic [nept_pkg::DIM_W-1:0] eff_h;
	logic [nept_pkg::SPP_W-1:0] eff_spp;
	logic [nept_pkg::S_W-1:0]   spp_last;

	// Control
	nept_pkg::state_t state_q, state_d;
	logic req_acc;
	logic rsp_free;
	logic query_oob;
	logic step_issue;
	logic step_last;

	// Query context
	logic [nept_pkg::X_W-1:0]   qx_q;
	logic [nept_pkg::Y_W-1:0]   qy_q;
	logic [nept_pkg::POS_W-1:0] pos_q;
	logic [nept_pkg::S_W-1:0]   si_q;
	logic                       err_q;
	logic                       edge_q;
	logic [nept_pkg::VAL_W-1:0] centre_q;

	// Neighbor generation
	nept_pkg::off_t             dx, dy;
	logic [nept_pkg::X_W-1:0]   nx;
	logic [nept_pkg::Y_W-1:0]   ny;
	logic                       nx_ok, ny_ok;
	logic [nept_pkg::X_W-1:0]   px;
	logic [nept_pkg::Y_W-1:0]   py;
	logic [nept_pkg::PROD_W-1:0] pix_full;

	// Stage 1: pixel index formed
	logic                       wr_s1;
	logic                       rd_s1;
	logic                       last_s1;
	logic                       centre_s1;
	logic [nept_pkg::PIX_W-1:0] pix_s1;
	logic [nept_pkg::S_W-1:0]   si_s1;
	logic [nept_pkg::VAL_W-1:0] wdata_s1;

	// Stage 2: store read in flight
	logic                       rd_s2;
	logic                       last_s2;
	logic                       centre_s2;

	logic [nept_pkg::AFULL_W-1:0] addr_full;
	nept_pkg::mem_cmd_t           mem_cmd;
	logic [nept_pkg::VAL_W-1:0]   rd_data;
	logic [nept_pkg::VAL_W-1:0]   ref_val;
	logic [nept_pkg::VAL_W-1:0]   diff;

	// Output register
	logic           rsp_valid_q;
	nept_pkg::rsp_t rsp_q;

	assign eff_w    = nept_pkg::clamp_dim(width_q, nept_pkg::DIM_W'(nept_pkg::MAX_WIDTH));
	assign eff_h    = nept_pkg::clamp_dim(height_q, nept_pkg::DIM_W'(nept_pkg::MAX_HEIGHT));
	assign eff_spp  = nept_pkg::clamp_spp(spp_q);
	assign spp_last = nept_pkg::S_W'(eff_spp - nept_pkg::SPP_W'(1));

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nept_pkg::DIM_W'(128);
			height_q <= nept_pkg::DIM_W'(128);
			spp_q    <= nept_pkg::SPP_W'(1);
			tol_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				nept_pkg::CFG_WIDTH:     width_q  <= cfg_data[nept_pkg::DIM_W-1:0];
				nept_pkg::CFG_HEIGHT:    height_q <= cfg_data[nept_pkg::DIM_W-1:0];
				nept_pkg::CFG_SAMPLES:   spp_q    <= cfg_data[nept_pkg::SPP_W-1:0];
				nept_pkg::CFG_TOLERANCE: tol_q    <= cfg_data[nept_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign query_oob = ({1'b0, req.x} >= eff_w) || ({1'b0, req.y} >= eff_h);

	// Next state and step control
	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		step_issue = 1'b0;
		step_last  = 1'b0;
		case (state_q)
			nept_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req.req_type == nept_pkg::REQ_QUERY)
					state_d = query_oob ? nept_pkg::ST_FINISH : nept_pkg::ST_RUN;
			end
			nept_pkg::ST_RUN: begin
				step_issue = 1'b1;
				step_last  = (pos_q == nept_pkg::POS_LAST) && (si_q == spp_last);
				if (step_last)
					state_d = nept_pkg::ST_DRAIN;
			end
			nept_pkg::ST_DRAIN: begin
				if (last_s2)
					state_d = nept_pkg::ST_FINISH;
			end
			nept_pkg::ST_FINISH: begin
				if (rsp_free)
					state_d = nept_pkg::ST_IDLE;
			end
			default: state_d = nept_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nept_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Latch the query and advance the walk
	always_ff @(posedge clk) begin
		if (req_acc && req.req_type == nept_pkg::REQ_QUERY) begin
			qx_q  <= req.x;
			qy_q  <= req.y;
			err_q <= query_oob;
			pos_q <= nept_pkg::POS_CENTRE;
			si_q  <= '0;
		end else if (step_issue) begin
			if (pos_q == nept_pkg::POS_LAST) begin
				pos_q <= nept_pkg::POS_CENTRE;
				si_q  <= si_q + nept_pkg::S_W'(1);
			end else begin
				pos_q <= pos_q + nept_pkg::POS_W'(1);
			end
		end
	end

	// Neighbor coordinates and bounds
	always_comb begin
		dx    = nept_pkg::pos_dx(pos_q);
		dy    = nept_pkg::pos_dy(pos_q);
		nx    = qx_q;
		ny    = qy_q;
		nx_ok = 1'b1;
		ny_ok = 1'b1;
		case (dx)
			nept_pkg::OFF_NEG: begin
				nx    = qx_q - nept_pkg::X_W'(1);
				nx_ok = (qx_q != '0);
			end
			nept_pkg::OFF_POS: begin
				nx    = qx_q + nept_pkg::X_W'(1);
				nx_ok = ({1'b0, qx_q} + nept_pkg::DIM_W'(1)) < eff_w;
			end
			default: ;
		endcase
		case (dy)
			nept_pkg::OFF_NEG: begin
				ny    = qy_q - nept_pkg::Y_W'(1);
				ny_ok = (qy_q != '0);
			end
			nept_pkg::OFF_POS: begin
				ny    = qy_q + nept_pkg::Y_W'(1);
				ny_ok = ({1'b0, qy_q} + nept_pkg::DIM_W'(1)) < eff_h;
			end
			default: ;
		endcase
	end

	// Pixel index for a walk step or an incoming write
	assign px       = step_issue ? nx : req.x;
	assign py       = step_issue ? ny : req.y;
	assign pix_full = nept_pkg::PROD_W'(py) * nept_pkg::PROD_W'(eff_w)
		+ nept_pkg::PROD_W'(px);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1   <= 1'b0;
			rd_s1   <= 1'b0;
			last_s1 <= 1'b0;
		end else begin
			wr_s1   <= req_acc && req.req_type == nept_pkg::REQ_WRITE && !query_oob
				&& ({1'b0, req.sample} < eff_spp);
			rd_s1   <= step_issue && nx_ok && ny_ok;
			last_s1 <= step_last;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		pix_s1    <= pix_full[nept_pkg::PIX_W-1:0];
		si_s1     <= step_issue ? si_q : req.sample;
		centre_s1 <= (pos_q == nept_pkg::POS_CENTRE);
		wdata_s1  <= req.value;
	end

	// Store address and command
	assign addr_full = nept_pkg::AFULL_W'(pix_s1) * nept_pkg::AFULL_W'(eff_spp)
		+ nept_pkg::AFULL_W'(si_s1);

	always_comb begin
		mem_cmd.we    = wr_s1;
		mem_cmd.re    = rd_s1;
		mem_cmd.addr  = addr_full[nept_pkg::ADDR_W-1:0];
		mem_cmd.wdata = wdata_s1;
	end

	nept_ram u_ram (
		.clk     (clk),
		.cmd     (mem_cmd),
		.rd_data (rd_data)
	);

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s2   <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			rd_s2   <= rd_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		centre_s2 <= centre_s1;
	end

	// Compare each returned sample against the centre
	assign ref_val = centre_s2 ? rd_data : centre_q;
	assign diff    = (ref_val > rd_data) ? (ref_val - rd_data) : (rd_data - ref_val);

	always_ff @(posedge clk) begin
		if (req_acc && req.req_type == nept_pkg::REQ_QUERY) begin
			edge_q <= 1'b0;
		end else if (rd_s2) begin
			if (centre_s2)
				centre_q <= rd_data;
			if ({1'b0, diff} >= tol_q)
				edge_q <= 1'b1;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (state_q == nept_pkg::ST_FINISH && rsp_free)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == nept_pkg::ST_FINISH && rsp_free) begin
			rsp_q.is_edge     <= edge_q && !err_q;
			rsp_q.coord_error <= err_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The last walk step reaches the compare only while draining
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		last_s2 |-> state_q == nept_pkg::ST_DRAIN)
		else $error("last step outside drain");

	// Store writes never overlap a query walk
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_cmd.we |-> state_q == nept_pkg::ST_IDLE)
		else $error("store write during query");

	// A finished query with a free output register shows a result next
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nept_pkg::ST_FINISH && rsp_free) |=> rsp_valid_q)
		else $error("result not presented");

	// An out-of-image answer never reports an edge
	a_err_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.coord_error) |-> !rsp_q.is_edge)
		else $error("edge reported with coordinate error");

endmodule

// File: tb/tb_top.sv
module tb_top;
	import nept_pkg::*;

	localparam int RANDOM_ITEMS   = 1250;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 60;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req_item  = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp_word;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;

	neighborhood_edge_pixel_test u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Transactions waiting for the driver, and edge answers waiting for the block
	req_t pending_q[$];
	rsp_t edge_expect_q[$];
	int   sent_count      = 0;
	int   taken_count     = 0;
	int   useful_count    = 0;
	int   results_checked = 0;
	int   mismatches      = 0;
	int   drv_idle_pct    = 0;
	int   rcv_stall_pct   = 0;

	// Stimulus view: register values last programmed and store entries written so far
	int gen_width  = MAX_WIDTH;
	int gen_height = MAX_HEIGHT;
	int gen_spp    = 1;
	bit written_map [DEPTH];

	// Predictor view: registers and image as the block should hold them
	logic [DIM_W-1:0] width_reg  = DIM_W'(MAX_WIDTH);
	logic [DIM_W-1:0] height_reg = DIM_W'(MAX_HEIGHT);
	logic [SPP_W-1:0] spp_reg    = SPP_W'(1);
	logic [TOL_W-1:0] tol_reg    = '0;
	bit [VAL_W-1:0]   image_store [DEPTH];

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int clamp_reg(int v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int store_addr(int x, int y, int s, int w, int spp);
		return (y * w + x) * spp + s;
	endfunction

	// Mostly no gap; when there is one, mostly short and now and then long
	function automatic int pick_gap(int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic int extreme_dim();
		case ($urandom_range(4))
			0:       return 0;
			1:       return 1;
			2:       return MAX_WIDTH;
			3:       return 255;
			default: return $urandom_range(511);
		endcase
	endfunction

	function automatic int sample_near(int base, int spread);
		int v;
		if (spread >= 255)
			return $urandom_range(255);
		v = base + $urandom_range(spread);
		return (v > 255) ? 255 : v;
	endfunction

	// Edge answer for a query against the predicted image
	function automatic rsp_t predict_query(req_t r);
		rsp_t res;
		int   w, h, spp, nx, ny, centre, other, diff;
		res = '0;
		w   = clamp_reg(int'(width_reg), MAX_WIDTH);
		h   = clamp_reg(int'(height_reg), MAX_HEIGHT);
		spp = clamp_reg(int'(spp_reg), MAX_SAMPLES);
		if (int'(r.x) >= w || int'(r.y) >= h) begin
			res.coord_error = 1'b1;
			return res;
		end
		for (int s = 0; s < spp; s++) begin
			centre = image_store[store_addr(r.x, r.y, s, w, spp)];
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					nx = int'(r.x) + dx;
					ny = int'(r.y) + dy;
					if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
						other = image_store[store_addr(nx, ny, s, w, spp)];
						diff  = (centre > other) ? centre - other : other - centre;
						if (diff >= int'(tol_reg))
							res.is_edge = 1'b1;
					end
				end
			end
		end
		return res;
	endfunction

	// A query is safe when it lies outside the image or every sample it reads was written
	function automatic bit query_ready(int x, int y);
		int w, h, spp, nx, ny;
		w   = clamp_reg(gen_width, MAX_WIDTH);
		h   = clamp_reg(gen_height, MAX_HEIGHT);
		spp = clamp_reg(gen_spp, MAX_SAMPLES);
		if (x >= w || y >= h)
			return 1'b1;
		for (int s = 0; s < spp; s++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				for (int dy = -1; dy <= 1; dy++) begin
					nx = x + dx;
					ny = y + dy;
					if (nx >= 0 && nx < w && ny >= 0 && ny < h &&
							!written_map[store_addr(nx, ny, s, w, spp)])
						return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	task automatic push_item(logic kind, int x, int y, int s, int v);
		req_t it;
		int   w, h, spp;
		w           = clamp_reg(gen_width, MAX_WIDTH);
		h           = clamp_reg(gen_height, MAX_HEIGHT);
		spp         = clamp_reg(gen_spp, MAX_SAMPLES);
		it.req_type = kind;
		it.x        = X_W'(x);
		it.y        = Y_W'(y);
		it.sample   = S_W'(s);
		it.value    = VAL_W'(v);
		pending_q.push_back(it);
		sent_count++;
		if (kind == REQ_QUERY) begin
			useful_count++;
		end else if (x < w && y < h && s < spp) begin
			written_map[store_addr(x, y, s, w, spp)] = 1'b1;
			useful_count++;
		end
	endtask

	task automatic wait_drained();
		while (taken_count != sent_count || edge_expect_q.size() != 0)
			@(posedge clk);
	endtask

	// Program all registers once the block has gone quiet
	task automatic program_image(int wd, int hd, int sd, int td);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data  <= CFG_W'(wd);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data  <= CFG_W'(hd);
		@(posedge clk);
		cfg_index <= CFG_SAMPLES;
		cfg_data  <= CFG_W'(sd);
		@(posedge clk);
		cfg_index <= CFG_TOLERANCE;
		cfg_data  <= CFG_W'(td);
		@(posedge clk);
		cfg_we     <= 1'b0;
		gen_width  = wd & 'hFF;
		gen_height = hd & 'hFF;
		gen_spp    = sd & 'h7;
	endtask

	// One setting: fill a window of the image, then mix queries, rewrites and dropped writes
	task automatic random_phase();
		int wd, hd, sd, td, w, h, spp, wx, wy, x0, y0, base, spread, steps, pick, x, y;
		wd = ($urandom_range(5) == 0) ? extreme_dim() :
			($urandom_range(8, 1) | ($urandom_range(1) << 8));
		hd = ($urandom_range(5) == 0) ? extreme_dim() :
			($urandom_range(8, 1) | ($urandom_range(1) << 8));
		sd = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(4, 1);
		case ($urandom_range(3))
			0:       spread = 0;
			1:       spread = $urandom_range(8, 1);
			2:       spread = $urandom_range(60, 9);
			default: spread = 255;
		endcase
		case ($urandom_range(9))
			0:       td = 0;
			1:       td = 255;
			2:       td = 256;
			3:       td = $urandom_range(511, 257);
			default: td = $urandom_range(spread + 2);
		endcase
		base = $urandom_range(255);
		case ($urandom_range(2))
			0:       drv_idle_pct <= 0;
			1:       drv_idle_pct <= 15;
			default: drv_idle_pct <= 45;
		endcase
		case ($urandom_range(2))
			0:       rcv_stall_pct <= 0;
			1:       rcv_stall_pct <= 15;
			default: rcv_stall_pct <= 45;
		endcase
		program_image(wd, hd, sd, td);

		w   = clamp_reg(gen_width, MAX_WIDTH);
		h   = clamp_reg(gen_height, MAX_HEIGHT);
		spp = clamp_reg(gen_spp, MAX_SAMPLES);
		wx  = $urandom_range(6, 1);
		wy  = $urandom_range(6, 1);
		if (wx > w)
			wx = w;
		if (wy > h)
			wy = h;
		// lean toward the far corner so the top coordinates get exercised
		x0 = ($urandom_range(2) == 0) ? w - wx : $urandom_range(w - wx);
		y0 = ($urandom_range(2) == 0) ? h - wy : $urandom_range(h - wy);

		for (y = y0; y < y0 + wy; y++)
			for (x = x0; x < x0 + wx; x++)
				for (int s = 0; s < spp; s++)
					push_item(REQ_WRITE, x, y, s, sample_near(base, spread));

		steps = $urandom_range(60, 20);
		repeat (steps) begin
			pick = $urandom_range(99);
			x    = x0 + $urandom_range(wx - 1);
			y    = y0 + $urandom_range(wy - 1);
			if (pick < 45) begin
				if (query_ready(x, y))
					push_item(REQ_QUERY, x, y, $urandom_range(3), $urandom_range(255));
			end else if (pick < 80) begin
				push_item(REQ_WRITE, x, y, $urandom_range(spp - 1), sample_near(base, spread));
			end else if (pick < 92) begin
				// any coordinate; outside the image this is a coordinate error
				x = $urandom_range(127);
				y = $urandom_range(127);
				if (query_ready(x, y))
					push_item(REQ_QUERY, x, y, $urandom_range(3), $urandom_range(255));
			end else begin
				// mostly lands beyond the image or the pixel's samples and is dropped
				push_item(REQ_WRITE, $urandom_range(127), $urandom_range(127),
					$urandom_range(3), $urandom_range(255));
			end
		end
	endtask

	// Drive request transactions from the pending queue with random gaps
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			gap_left  <= 0;
		end else if (!req_valid || !req_stall) begin
			if (gap_left != 0) begin
				gap_left  <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				req_item  <= pending_q.pop_front();
				req_valid <= 1'b1;
				gap_left  <= pick_gap(drv_idle_pct);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Stall results at random; once, hold off long enough for the block to back up
	int hold_left      = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (!long_hold_done && results_checked >= 40 && pending_q.size() > 20) begin
			long_hold_done <= 1'b1;
			hold_left      <= LONG_HOLD;
			rsp_stall      <= 1'b1;
		end else begin
			g = pick_gap(rcv_stall_pct);
			hold_left <= (g != 0) ? g - 1 : 0;
			rsp_stall <= (g != 0);
		end
	end

	// Track registers, predict each accepted transaction, check each result
	always @(posedge clk) begin
		rsp_t want;
		int   w, h, spp;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_WIDTH:     width_reg  = cfg_data[DIM_W-1:0];
					CFG_HEIGHT:    height_reg = cfg_data[DIM_W-1:0];
					CFG_SAMPLES:   spp_reg    = cfg_data[SPP_W-1:0];
					CFG_TOLERANCE: tol_reg    = cfg_data[TOL_W-1:0];
					default:       ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (edge_expect_q.size() == 0) begin
					$error("result transaction with no query outstanding");
					mismatches++;
				end else begin
					want = edge_expect_q.pop_front();
					results_checked++;
					if (rsp_word.is_edge !== want.is_edge) begin
						$error("is_edge: expected %0b, got %0b", want.is_edge, rsp_word.is_edge);
						mismatches++;
					end
					if (rsp_word.coord_error !== want.coord_error) begin
						$error("coord_error: expected %0b, got %0b",
							want.coord_error, rsp_word.coord_error);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				taken_count++;
				if (req_item.req_type == REQ_QUERY) begin
					edge_expect_q.push_back(predict_query(req_item));
				end else begin
					w   = clamp_reg(int'(width_reg), MAX_WIDTH);
					h   = clamp_reg(int'(height_reg), MAX_HEIGHT);
					spp = clamp_reg(int'(spp_reg), MAX_SAMPLES);
					if (int'(req_item.x) < w && int'(req_item.y) < h && int'(req_item.sample) < spp)
						image_store[store_addr(req_item.x, req_item.y, req_item.sample, w, spp)] =
							req_item.value;
				end
			end
		end
	end

	// End the run when no transaction of any kind has moved for too long
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("neighborhood_edge_pixel_test: mismatch");
			$finish;
		end
	end

	initial begin
		int random_base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: 128 x 128, one sample, tolerance 0 marks every pixel
		push_item(REQ_WRITE, 126, 126, 0, 8'h00);
		push_item(REQ_WRITE, 127, 126, 0, 8'hFF);
		push_item(REQ_WRITE, 126, 127, 0, 8'h55);
		push_item(REQ_WRITE, 127, 127, 0, 8'hAA);
		push_item(REQ_QUERY, 127, 127, 0, 0);
		push_item(REQ_WRITE, 0, 0, 0, 8'h3C);
		push_item(REQ_WRITE, 1, 0, 0, 8'h3C);
		push_item(REQ_WRITE, 0, 1, 0, 8'h3C);
		push_item(REQ_WRITE, 1, 1, 0, 8'h3C);
		push_item(REQ_QUERY, 0, 0, 3, 8'hFF);
		// sample index beyond the pixel: dropped
		push_item(REQ_WRITE, 5, 5, 3, 8'hFF);

		// 2 x 1 image with two samples; the width's ninth bit is ignored
		program_image('h102, 1, 2, 255);
		push_item(REQ_WRITE, 0, 0, 0, 8'h00);
		push_item(REQ_WRITE, 1, 0, 0, 8'hFF);
		push_item(REQ_WRITE, 0, 0, 1, 8'h07);
		push_item(REQ_WRITE, 1, 0, 1, 8'h07);
		push_item(REQ_QUERY, 0, 0, 0, 0);
		push_item(REQ_QUERY, 2, 0, 0, 0);
		push_item(REQ_QUERY, 0, 1, 0, 0);
		push_item(REQ_QUERY, 127, 127, 0, 0);

		// tolerance above any difference never finds an edge
		program_image('h102, 1, 2, 256);
		push_item(REQ_QUERY, 1, 0, 0, 0);

		random_base = useful_count;
		while (useful_count < random_base + RANDOM_ITEMS)
			random_phase();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("neighborhood_edge_pixel_test: match");
		else
			$display("neighborhood_edge_pixel_test: mismatch");
		$finish;
	end

endmodule

// File: neighborhood_edge_pixel_test.f
rtl/nept_pkg.sv
rtl/nept_ram.sv
rtl/neighborhood_edge_pixel_test.sv
tb/tb_top.sv
